// ----- rtl/clp_pkg.sv -----
`default_nettype none

package clp_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int SEL_IN_W    = 6;
  localparam int TS_W        = 64;
  localparam int TIME_W      = 32;
  localparam int DEPTH_OUT_W = 8;

  // Configuration register indexes.
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_DIVISOR = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_STARTED    = 3'd0,
    ST_NESTED     = 3'd1,
    ST_RECORDED   = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_NO_DIVISOR = 3'd4,
    ST_DISABLED   = 3'd5,
    ST_NEST_ERROR = 3'd6
  } status_t;

  // One event as held in the queue; the selector is already reduced.
  typedef struct packed {
    logic                req_type;
    logic [SEL_IN_W-1:0] selector;
    logic [TS_W-1:0]     timestamp;
    logic                error_flag;
  } item_t;

  // One result transaction.
  typedef struct packed {
    status_t                status;
    logic [TIME_W-1:0]      elapsed_time;
    logic [DEPTH_OUT_W-1:0] nest_depth;
    logic [TIME_W-1:0]      call_count;
    logic [TIME_W-1:0]      error_count;
    logic [TIME_W-1:0]      min_time;
    logic [TIME_W-1:0]      max_time;
    logic [TS_W-1:0]        total_time;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/call_latency_profiler.sv -----
// Per-selector call latency profiler. Each input transaction is a call start
// or call end event for one selector; each produces exactly one result
// transaction showing the selector's statistics after the event. A front end
// takes events into a two-entry queue at one per cycle, while it is not full,
// as the back end works; the back end handles one event at a time. An event
// other than a recorded outermost end goes through queue pop with table read,
// classification, and write-back with result load, held while a result waits.
// A recorded outermost end also passes the 32-step bit-serial divider that
// divides elapsed ticks by the divisor. Registers are written through
// cfg_we/cfg_index/cfg_wdata (index 0 enable, index 1 divisor); the user
// must write them only while the block is idle (not enforced). The table
// reads as all zero after reset with no clearing pass.
`default_nettype none

module call_latency_profiler #(
  parameter int NUM_SELECTORS = 64,
  parameter int DEPTH_BITS    = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [clp_pkg::TIME_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_req_type,
  input  wire logic [clp_pkg::SEL_IN_W-1:0] in_selector,
  input  wire logic [clp_pkg::TS_W-1:0]     in_timestamp,
  input  wire logic                         in_error_flag,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        out_status,
  output logic [clp_pkg::TIME_W-1:0]        out_elapsed_time,
  output logic [clp_pkg::DEPTH_OUT_W-1:0]   out_nest_depth,
  output logic [clp_pkg::TIME_W-1:0]        out_call_count,
  output logic [clp_pkg::TIME_W-1:0]        out_error_count,
  output logic [clp_pkg::TIME_W-1:0]        out_min_time,
  output logic [clp_pkg::TIME_W-1:0]        out_max_time,
  output logic [clp_pkg::TS_W-1:0]          out_total_time
);

  logic                       enable_r;
  logic [clp_pkg::TIME_W-1:0] divisor_r;
  clp_pkg::item_t             in_item;
  clp_pkg::item_t             q_item;
  logic                       q_valid;
  logic                       q_pop;
  clp_pkg::result_t           res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      divisor_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clp_pkg::CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        clp_pkg::CFG_DIVISOR: divisor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pack the input transaction.
  always_comb begin
    in_item.req_type   = in_req_type;
    in_item.selector   = in_selector;
    in_item.timestamp  = in_timestamp;
    in_item.error_flag = in_error_flag;
  end

  clp_front #(
    .NUM_SELECTORS (NUM_SELECTORS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  clp_back #(
    .NUM_SELECTORS (NUM_SELECTORS),
    .DEPTH_BITS    (DEPTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .divisor   (divisor_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Unpack the result transaction.
  assign out_status       = res.status;
  assign out_elapsed_time = res.elapsed_time;
  assign out_nest_depth   = res.nest_depth;
  assign out_call_count   = res.call_count;
  assign out_error_count  = res.error_count;
  assign out_min_time     = res.min_time;
  assign out_max_time     = res.max_time;
  assign out_total_time   = res.total_time;

  // A recorded time lies within the updated minimum and maximum.
  a_rec_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res.status == clp_pkg::ST_RECORDED) |->
      (out_min_time <= out_elapsed_time) && (out_max_time >= out_elapsed_time)
      && (out_call_count != '0))
    else $error("recorded time outside min/max bounds");

  // Only recorded results carry an elapsed time.
  a_elapsed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res.status != clp_pkg::ST_RECORDED) |-> (out_elapsed_time == '0))
    else $error("elapsed time on a result that was not recorded");

  // An outermost start leaves the depth at one.
  a_start_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (res.status == clp_pkg::ST_STARTED) |->
      (out_nest_depth == clp_pkg::DEPTH_OUT_W'(1)))
    else $error("outermost start with depth other than one");

endmodule

`default_nettype wire

// ----- rtl/clp_front.sv -----
`default_nettype none

module clp_front #(
  parameter int NUM_SELECTORS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire clp_pkg::item_t in_item,
  output logic                q_valid,
  output clp_pkg::item_t      q_item,
  input  wire logic           q_pop
);

  localparam int SEL_VALS = 1 << clp_pkg::SEL_IN_W;

  // Constant table that folds a raw selector onto the table range.
  logic [clp_pkg::SEL_IN_W-1:0] sel_mod [SEL_VALS];

  for (genvar i = 0; i < SEL_VALS; i++) begin : g_mod
    assign sel_mod[i] = clp_pkg::SEL_IN_W'(i % NUM_SELECTORS);
  end

  // Two-entry queue between the input channel and the back end.
  clp_pkg::item_t q_mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           pop;
  clp_pkg::item_t item_cls;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Classify the incoming transaction: reduce the selector.
  always_comb begin
    item_cls          = in_item;
    item_cls.selector = sel_mod[in_item.selector];
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/clp_div.sv -----
`default_nettype none

module clp_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [clp_pkg::TIME_W-1:0]  dividend,
  input  wire logic [clp_pkg::TIME_W-1:0]  divisor,
  output logic                             done,
  output logic [clp_pkg::TIME_W-1:0]       quotient
);

  localparam int W   = clp_pkg::TIME_W;
  localparam int CW  = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [W:0]    trial;
  logic [W-1:0]  rem_nxt;
  logic          qbit;

  assign done     = done_r;
  assign quotient = quo_r;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    qbit  = ~trial[W];
    if (qbit) begin
      rem_nxt = trial[W-1:0];
    end else begin
      rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
    end
  end

  // Iteration control: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/clp_back.sv -----
`default_nettype none

module clp_back #(
  parameter int NUM_SELECTORS = 64,
  parameter int DEPTH_BITS    = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       enable,
  input  wire logic [clp_pkg::TIME_W-1:0] divisor,
  input  wire logic                       q_valid,
  input  wire clp_pkg::item_t             q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output clp_pkg::result_t                out_res
);

  localparam int SEL_W  = $clog2(NUM_SELECTORS);
  localparam int DW_EXT = (DEPTH_BITS > clp_pkg::DEPTH_OUT_W) ? DEPTH_BITS
                                                               : clp_pkg::DEPTH_OUT_W;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  // One table row per selector.
  typedef struct packed {
    logic [DEPTH_BITS-1:0]      depth;
    logic [clp_pkg::TS_W-1:0]   start;
    logic [clp_pkg::TIME_W-1:0] min_t;
    logic [clp_pkg::TIME_W-1:0] max_t;
    logic [clp_pkg::TS_W-1:0]   total;
    logic [clp_pkg::TIME_W-1:0] count;
    logic [clp_pkg::TIME_W-1:0] errcount;
  } row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state_r;
  row_t                 mem_r [NUM_SELECTORS];
  logic [NUM_SELECTORS-1:0] row_vld_r;
  row_t                 rd_row_r;
  logic                 rd_vld_r;
  row_t                 work_r;
  row_t                 work_nxt;
  row_t                 entry;
  clp_pkg::item_t       cur_r;
  logic [SEL_W-1:0]     sel_r;
  logic [SEL_W-1:0]     rd_addr;
  clp_pkg::status_t     status_r;
  clp_pkg::status_t     status_nxt;
  logic [clp_pkg::TIME_W-1:0] elapsed_r;
  logic [clp_pkg::TS_W-1:0]   span;
  logic                 go_div;
  logic                 mem_we;
  logic                 out_valid_r;
  clp_pkg::result_t     out_res_r;
  clp_pkg::result_t     res_nxt;
  logic [DW_EXT-1:0]    depth_ext;
  logic                 div_start;
  logic                 div_done;
  logic [clp_pkg::TIME_W-1:0] div_q;
  row_t                 stat_nxt;

  assign q_pop     = (state_r == S_IDLE);
  assign rd_addr   = SEL_W'(q_item.selector);
  assign entry     = rd_vld_r ? rd_row_r : '0;
  assign span      = cur_r.timestamp - entry.start;
  assign div_start = (state_r == S_EVAL) && go_div;
  assign mem_we    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  clp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (span[clp_pkg::TIME_W-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Classify the event against the selector's entry.
  always_comb begin
    work_nxt   = entry;
    status_nxt = clp_pkg::ST_DISABLED;
    go_div     = 1'b0;
    if (enable) begin
      if (!cur_r.req_type) begin
        if (entry.depth == DEPTH_MAX) begin
          status_nxt = clp_pkg::ST_NEST_ERROR;
        end else begin
          work_nxt.depth = entry.depth + DEPTH_ONE;
          if (entry.depth == '0) begin
            work_nxt.start = cur_r.timestamp;
            status_nxt     = clp_pkg::ST_STARTED;
          end else begin
            status_nxt = clp_pkg::ST_NESTED;
          end
        end
      end else begin
        if (entry.depth == '0) begin
          status_nxt = clp_pkg::ST_NEST_ERROR;
        end else begin
          work_nxt.depth = entry.depth - DEPTH_ONE;
          if (entry.depth != DEPTH_ONE) begin
            status_nxt = clp_pkg::ST_NESTED;
          end else if (divisor == '0) begin
            status_nxt = clp_pkg::ST_NO_DIVISOR;
          end else if (span[clp_pkg::TS_W-1:clp_pkg::TIME_W] != '0) begin
            status_nxt = clp_pkg::ST_TOO_LONG;
          end else begin
            status_nxt = clp_pkg::ST_RECORDED;
            go_div     = 1'b1;
          end
        end
      end
    end
  end

  // Fold the divided elapsed time into the statistics.
  always_comb begin
    stat_nxt = work_r;
    if (div_q > work_r.max_t) begin
      stat_nxt.max_t = div_q;
    end
    if ((div_q < work_r.min_t) || (work_r.min_t == '0)) begin
      stat_nxt.min_t = div_q;
    end
    stat_nxt.count = work_r.count + clp_pkg::TIME_W'(1);
    if (cur_r.error_flag) begin
      stat_nxt.errcount = work_r.errcount + clp_pkg::TIME_W'(1);
    end
    stat_nxt.total = work_r.total + clp_pkg::TS_W'(div_q);
  end

  // Result assembled from the updated row.
  always_comb begin
    depth_ext            = DW_EXT'(work_r.depth);
    res_nxt.status       = status_r;
    res_nxt.elapsed_time = elapsed_r;
    res_nxt.nest_depth   = depth_ext[clp_pkg::DEPTH_OUT_W-1:0];
    res_nxt.call_count   = work_r.count;
    res_nxt.error_count  = work_r.errcount;
    res_nxt.min_time     = work_r.min_t;
    res_nxt.max_time     = work_r.max_t;
    res_nxt.total_time   = work_r.total;
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !mem_we) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            sel_r   <= rd_addr;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          work_r    <= work_nxt;
          status_r  <= status_nxt;
          elapsed_r <= '0;
          state_r   <= go_div ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            work_r    <= stat_nxt;
            elapsed_r <= div_q;
            state_r   <= S_DONE;
          end
        end
        S_DONE: begin
          if (mem_we) begin
            out_valid_r <= 1'b1;
            out_res_r   <= res_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Row valid bits: a row never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_r[sel_r] <= 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // Statistics table.
  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      rd_row_r <= mem_r[rd_addr];
    end
    if (mem_we) begin
      mem_r[sel_r] <= work_r;
    end
  end

endmodule

`default_nettype wire

// ----- tb/call_latency_profiler_test.sv -----
`timescale 1ns / 100ps

// Tracks the profiler table from observed transactions and checks results.
class profile_tracker;
  localparam int ENTRIES = 64;
  localparam logic [7:0] DEPTH_FULL = 8'hFF;

  bit          enabled;
  logic [31:0] divisor;
  logic [7:0]  depth_tab[ENTRIES];
  logic [63:0] start_tab[ENTRIES];
  logic [31:0] min_tab[ENTRIES];
  logic [31:0] max_tab[ENTRIES];
  logic [63:0] total_tab[ENTRIES];
  logic [31:0] calls_tab[ENTRIES];
  logic [31:0] errors_tab[ENTRIES];
  clp_pkg::result_t expected_results[$];
  int unsigned mismatches;

  function new();
    enabled = 1'b0;
    divisor = '0;
    mismatches = 0;
    foreach (depth_tab[i]) begin
      depth_tab[i] = '0;
      start_tab[i] = '0;
      min_tab[i] = '0;
      max_tab[i] = '0;
      total_tab[i] = '0;
      calls_tab[i] = '0;
      errors_tab[i] = '0;
    end
  endfunction

  function void write_register(logic idx, logic [31:0] value);
    if (idx == clp_pkg::CFG_ENABLE) enabled = value[0];
    else divisor = value;
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  // Applies one accepted event to the table and queues the expected result.
  function void note_event(logic is_end, logic [5:0] sel, logic [63:0] ts, logic err);
    clp_pkg::result_t r;
    int unsigned s;
    logic [7:0]  d;
    logic [63:0] span;
    logic [31:0] ticks;
    r = '0;
    r.status = clp_pkg::ST_DISABLED;
    s = sel;
    d = depth_tab[s];
    if (enabled) begin
      if (!is_end) begin
        if (d == DEPTH_FULL) begin
          r.status = clp_pkg::ST_NEST_ERROR;
        end else begin
          if (d == 0) begin
            start_tab[s] = ts;
            r.status = clp_pkg::ST_STARTED;
          end else begin
            r.status = clp_pkg::ST_NESTED;
          end
          depth_tab[s] = d + 8'd1;
        end
      end else if (d == 0) begin
        r.status = clp_pkg::ST_NEST_ERROR;
      end else begin
        depth_tab[s] = d - 8'd1;
        span = ts - start_tab[s];
        if (d != 8'd1) begin
          r.status = clp_pkg::ST_NESTED;
        end else if (divisor == 0) begin
          r.status = clp_pkg::ST_NO_DIVISOR;
        end else if (span[63:32] != 0) begin
          r.status = clp_pkg::ST_TOO_LONG;
        end else begin
          // Outermost end of a measurable call: fold it into the statistics.
          ticks = span[31:0] / divisor;
          if (ticks > max_tab[s]) max_tab[s] = ticks;
          if (ticks < min_tab[s] || min_tab[s] == 0) min_tab[s] = ticks;
          calls_tab[s] = calls_tab[s] + 32'd1;
          if (err) errors_tab[s] = errors_tab[s] + 32'd1;
          total_tab[s] = total_tab[s] + {32'd0, ticks};
          r.status = clp_pkg::ST_RECORDED;
          r.elapsed_time = ticks;
        end
      end
    end
    r.nest_depth = depth_tab[s];
    r.call_count = calls_tab[s];
    r.error_count = errors_tab[s];
    r.min_time = min_tab[s];
    r.max_time = max_tab[s];
    r.total_time = total_tab[s];
    expected_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compares one accepted result with the oldest expectation.
  function void check_result(clp_pkg::result_t got);
    clp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result mismatch, expected none, actual status %0d", $time,
               got.status);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("elapsed_time", 64'(want.elapsed_time), 64'(got.elapsed_time));
    compare_field("nest_depth", 64'(want.nest_depth), 64'(got.nest_depth));
    compare_field("call_count", 64'(want.call_count), 64'(got.call_count));
    compare_field("error_count", 64'(want.error_count), 64'(got.error_count));
    compare_field("min_time", 64'(want.min_time), 64'(got.min_time));
    compare_field("max_time", 64'(want.max_time), 64'(got.max_time));
    compare_field("total_time", want.total_time, got.total_time);
  endfunction
endclass

module call_latency_profiler_test;
  localparam logic EV_START = 1'b0;
  localparam logic EV_END   = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = clp_pkg::CFG_ENABLE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = EV_START;
  logic [5:0]  in_selector = '0;
  logic [63:0] in_timestamp = '0;
  logic        in_error_flag = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_elapsed_time;
  logic [7:0]  out_nest_depth;
  logic [31:0] out_call_count;
  logic [31:0] out_error_count;
  logic [31:0] out_min_time;
  logic [31:0] out_max_time;
  logic [63:0] out_total_time;

  profile_tracker   tracker = new();
  clp_pkg::result_t seen_result;
  bit               quiet_tail = 1'b0;
  int unsigned      events_sent = 0;
  int unsigned      stall_left = 0;

  call_latency_profiler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_selector      (in_selector),
    .in_timestamp     (in_timestamp),
    .in_error_flag    (in_error_flag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_elapsed_time (out_elapsed_time),
    .out_nest_depth   (out_nest_depth),
    .out_call_count   (out_call_count),
    .out_error_count  (out_error_count),
    .out_min_time     (out_min_time),
    .out_max_time     (out_max_time),
    .out_total_time   (out_total_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe register writes and both channels at every rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_register(cfg_index, cfg_wdata);
      if (out_valid && out_ready) begin
        seen_result.status = clp_pkg::status_t'(out_status);
        seen_result.elapsed_time = out_elapsed_time;
        seen_result.nest_depth = out_nest_depth;
        seen_result.call_count = out_call_count;
        seen_result.error_count = out_error_count;
        seen_result.min_time = out_min_time;
        seen_result.max_time = out_max_time;
        seen_result.total_time = out_total_time;
        tracker.check_result(seen_result);
      end
      if (in_valid && in_ready)
        tracker.note_event(in_req_type, in_selector, in_timestamp, in_error_flag);
    end
  end

  // The result side stalls in random bursts until the quiet tail of the run.
  always @(posedge clk) begin
    if (!quiet_tail && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Presents one event, after an optional random gap, and waits for the transaction.
  task automatic send_event(logic kind, logic [5:0] sel, logic [63:0] ts, logic err);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_selector <= sel;
    in_timestamp <= ts;
    in_error_flag <= err;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  // Stops the input side and waits until every expected result has arrived.
  task automatic finish_batch();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic enable, logic [31:0] divisor);
    cfg_we <= 1'b1;
    cfg_index <= clp_pkg::CFG_ENABLE;
    cfg_wdata <= {31'd0, enable};
    @(posedge clk);
    cfg_index <= clp_pkg::CFG_DIVISOR;
    cfg_wdata <= divisor;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One balanced call, possibly nested, with a span drawn from several ranges.
  task automatic run_call_sequence();
    logic [5:0]  sel;
    int unsigned levels;
    int unsigned pick;
    logic [63:0] base;
    logic [63:0] span;
    logic [63:0] ts;
    sel = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63));
    levels = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
    pick = $urandom_range(0, 99);
    if (pick < 70) span = 64'($urandom_range(0, 1 << 20));
    else if (pick < 85) span = {32'd0, $urandom};
    else if (pick < 95) span = {32'($urandom_range(1, 32'hFFFF_FFFF)), $urandom};
    else span = ($urandom_range(0, 1) == 0) ? 64'h0000_0001_0000_0000 : 64'h0000_0000_FFFF_FFFF;
    base = random_word();
    for (int i = 0; i < levels; i++)
      send_event(EV_START, sel, base + 64'(i), 1'($urandom));
    for (int i = 0; i < levels; i++) begin
      ts = (i == levels - 1) ? base + span : random_word();
      send_event(EV_END, sel, ts, 1'($urandom));
    end
  endtask

  // Mostly well-formed calls, with some unbalanced events mixed in.
  task automatic run_phase(logic enable, logic [31:0] divisor, int unsigned budget);
    int unsigned target;
    finish_batch();
    write_config(enable, divisor);
    target = events_sent + budget;
    while (events_sent < target) begin
      if ($urandom_range(0, 99) < 15)
        send_event(1'($urandom), 6'($urandom), random_word(), 1'($urandom));
      else
        run_call_sequence();
    end
  endtask

  // Drives one selector past the deepest nesting and back below zero.
  task automatic run_deep_nesting();
    logic [5:0]  sel;
    logic [63:0] base;
    sel = 6'($urandom);
    base = random_word();
    for (int i = 0; i < 256; i++)
      send_event(EV_START, sel, base + 64'(i), 1'($urandom));
    for (int i = 0; i < 256; i++)
      send_event(EV_END, sel, base + 64'd123456 + 64'(i), 1'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Profiling is off after reset.
    send_event(EV_START, 6'd5, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_event(EV_END, 6'd5, 64'hFEDC_BA98_7654_3210, 1'b1);

    // Divisor not set: the outermost end is not recorded, then an unbalanced end.
    finish_batch();
    write_config(1'b1, 32'd0);
    send_event(EV_START, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_event(EV_END, 6'd0, 64'd0, 1'b1);
    send_event(EV_END, 6'd0, 64'd0, 1'b0);

    // Unit divisor: timestamp wrap, largest span, too long, nesting and zero time.
    finish_batch();
    write_config(1'b1, 32'd1);
    send_event(EV_START, 6'd63, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    send_event(EV_END, 6'd63, 64'h10, 1'b1);
    send_event(EV_START, 6'd1, 64'd0, 1'b0);
    send_event(EV_END, 6'd1, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_event(EV_START, 6'd2, 64'd0, 1'b1);
    send_event(EV_END, 6'd2, 64'h0000_0001_0000_0000, 1'b0);
    send_event(EV_START, 6'd3, 64'd5, 1'b0);
    send_event(EV_START, 6'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_event(EV_END, 6'd3, 64'h5555_5555_5555_5555, 1'b1);
    send_event(EV_END, 6'd3, 64'd5, 1'b1);
    send_event(EV_START, 6'd3, 64'd100, 1'b0);
    send_event(EV_END, 6'd3, 64'd109, 1'b0);

    // Largest divisor: a full span scales to one, a short one to zero.
    finish_batch();
    write_config(1'b1, 32'hFFFF_FFFF);
    send_event(EV_START, 6'd4, 64'd0, 1'b0);
    send_event(EV_END, 6'd4, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_event(EV_START, 6'd4, 64'd20, 1'b0);
    send_event(EV_END, 6'd4, 64'd27, 1'b1);

    // Random traffic over several settings.
    run_phase(1'b1, 32'd1000, 100);
    run_phase(1'b1, 32'd4000000, 150);
    run_phase(1'b1, $urandom, 150);
    run_phase(1'b0, $urandom, 60);
    run_phase(1'b1, 32'd1, 100);
    run_deep_nesting();
    run_phase(1'b1, 32'd0, 60);
    run_phase(1'b1, 32'hFFFF_FFFF, 100);
    finish_batch();
    quiet_tail = 1'b1;
    run_phase(1'b1, 32'd1000, 150);

    finish_batch();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
